### rtl/lfrg_pkg.sv
package lfrg_pkg;

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 24;
    localparam int CNT_W    = 5;
    localparam int ADDR_W   = 4;
    localparam int APB_W    = 32;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_TOGGLE = 2'd1;
    localparam logic [1:0] REG_SLOPE  = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd500;
    localparam logic                TOGGLE_RST = 1'b1;
    localparam logic                SLOPE_RST  = 1'b0;

    localparam logic       MODE_SAMPLE  = 1'b0;
    localparam logic       MODE_REALIGN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_REM,
        S_MUL,
        S_DIV_IDX,
        S_DONE
    } t_state;

endpackage

### rtl/led_fade_ramp_generator_unit.sv
// A sample passes S_CHECK, S_DIV_REM when it wraps, S_MUL, S_DIV_IDX and S_DONE; the result is registered.
// A realign transaction completes in its accept cycle and produces no output.
// A new sample is accepted only in S_IDLE, after the last result is handed over; output stalls hold S_DONE.
// The 32-step radix-2 divider runs for the wrap remainder when a sample wraps, and once for the level.
// Reset is synchronous, active low: ramp start 0, slope rising, registers at defaults.
module led_fade_ramp_generator_unit #(
    parameter int LEVELS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // now[31:0]
    input  logic        i_s_tuser,  // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // level_index, falling, wrapped, zero fill
    output logic [((($clog2(LEVELS) + 2) + 7) / 8) * 8 - 1:0] o_m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lfrg_pkg::ADDR_W-1:0] paddr,
    input  logic [lfrg_pkg::APB_W-1:0]  pwdata,
    output logic [lfrg_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);

    localparam int LW     = $clog2(LEVELS);
    localparam int DATA_W = (((LW + 2) + 7) / 8) * 8;
    localparam int TW     = lfrg_pkg::TIME_W;
    localparam int PW     = lfrg_pkg::PERIOD_W;
    localparam int CW     = lfrg_pkg::CNT_W;
    localparam logic [TW-1:0] LMAX = TW'(LEVELS - 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(TW - 1);

    lfrg_pkg::t_state r_state, n_state;

    logic [PW-1:0]     r_period;
    logic              r_toggle;
    logic              r_init_slope;
    logic [TW-1:0]     r_start, n_start;
    logic              r_slope, n_slope;
    logic [TW-1:0]     r_now, n_now;
    logic [TW-1:0]     r_d, n_d;
    logic              r_wrap, n_wrap;
    logic [TW-1:0]     r_div_q, n_div_q;
    logic [PW-1:0]     r_div_r, n_div_r;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_m_valid, n_m_valid;
    logic [DATA_W-1:0] r_m_data, n_m_data;

    logic [PW-1:0] per_eff;
    logic [PW:0]   trial;
    logic          trial_ge;
    logic [PW-1:0] step_r;
    logic [TW-1:0] step_q;
    logic [TW-1:0] ramp_end;
    logic [TW-1:0] diff;
    logic [LW-1:0] idx_sat;
    logic [LW-1:0] idx_out;
    logic          s_fire;
    logic          cfg_wr;

    assign per_eff  = (r_period == '0) ? PW'(1) : r_period;
    assign trial    = {r_div_r, r_div_q[TW-1]};
    assign trial_ge = trial >= {1'b0, per_eff};
    assign step_r   = trial_ge ? PW'(trial - {1'b0, per_eff}) : trial[PW-1:0];
    assign step_q   = {r_div_q[TW-2:0], trial_ge};
    assign ramp_end = r_start + TW'(per_eff);
    assign diff     = r_now - r_start;
    assign idx_sat  = (r_div_q > LMAX) ? LMAX[LW-1:0] : r_div_q[LW-1:0];
    assign idx_out  = r_slope ? (LMAX[LW-1:0] - idx_sat) : idx_sat;

    assign o_s_tready = (r_state == lfrg_pkg::S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            lfrg_pkg::REG_PERIOD: prdata = lfrg_pkg::APB_W'(r_period);
            lfrg_pkg::REG_TOGGLE: prdata = lfrg_pkg::APB_W'(r_toggle);
            lfrg_pkg::REG_SLOPE:  prdata = lfrg_pkg::APB_W'(r_init_slope);
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_start   = r_start;
        n_slope   = r_slope;
        n_now     = r_now;
        n_d       = r_d;
        n_wrap    = r_wrap;
        n_div_q   = r_div_q;
        n_div_r   = r_div_r;
        n_cnt     = r_cnt;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;
        unique case (r_state)
            lfrg_pkg::S_IDLE: begin
                if (s_fire) begin
                    if (i_s_tuser == lfrg_pkg::MODE_REALIGN) begin
                        n_start = i_s_tdata;
                    end else begin
                        n_now   = i_s_tdata;
                        n_state = lfrg_pkg::S_CHECK;
                    end
                end
            end
            lfrg_pkg::S_CHECK: begin
                if (r_now >= ramp_end) begin
                    n_wrap  = 1'b1;
                    n_slope = r_slope ^ r_toggle;
                    n_div_q = diff;
                    n_div_r = '0;
                    n_cnt   = CNT_LAST;
                    n_state = lfrg_pkg::S_DIV_REM;
                end else begin
                    n_wrap  = 1'b0;
                    n_d     = diff;
                    n_state = lfrg_pkg::S_MUL;
                end
            end
            lfrg_pkg::S_DIV_REM: begin
                n_div_q = step_q;
                n_div_r = step_r;
                n_cnt   = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_start = r_now - TW'(step_r);
                    n_d     = TW'(step_r);
                    n_state = lfrg_pkg::S_MUL;
                end
            end
            lfrg_pkg::S_MUL: begin
                n_div_q = LMAX * r_d;
                n_div_r = '0;
                n_cnt   = CNT_LAST;
                n_state = lfrg_pkg::S_DIV_IDX;
            end
            lfrg_pkg::S_DIV_IDX: begin
                n_div_q = step_q;
                n_div_r = step_r;
                n_cnt   = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = lfrg_pkg::S_DONE;
                end
            end
            lfrg_pkg::S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = DATA_W'({r_wrap, r_slope, idx_out});
                    n_state   = lfrg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lfrg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lfrg_pkg::S_IDLE;
            r_period     <= lfrg_pkg::PERIOD_RST;
            r_toggle     <= lfrg_pkg::TOGGLE_RST;
            r_init_slope <= lfrg_pkg::SLOPE_RST;
            r_start      <= '0;
            r_slope      <= lfrg_pkg::SLOPE_RST;
            r_m_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_start   <= n_start;
            r_slope   <= n_slope;
            r_m_valid <= n_m_valid;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    lfrg_pkg::REG_PERIOD: r_period     <= pwdata[PW-1:0];
                    lfrg_pkg::REG_TOGGLE: r_toggle     <= pwdata[0];
                    lfrg_pkg::REG_SLOPE:  r_init_slope <= pwdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now    <= n_now;
        r_d      <= n_d;
        r_wrap   <= n_wrap;
        r_div_q  <= n_div_q;
        r_div_r  <= n_div_r;
        r_cnt    <= n_cnt;
        r_m_data <= n_m_data;
    end

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_tuser == lfrg_pkg::MODE_SAMPLE) |=> (r_state == lfrg_pkg::S_CHECK))
        else $error("Sample transaction did not start the wrap check.");

    a_realign_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_tuser == lfrg_pkg::MODE_REALIGN) |=> (r_start == $past(i_s_tdata)))
        else $error("Realign transaction did not move the ramp start.");

    a_div_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfrg_pkg::S_DIV_IDX && r_cnt == '0) |=> (r_state == lfrg_pkg::S_DONE))
        else $error("Level division did not hand over to the output stage.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == lfrg_pkg::S_DONE))
        else $error("Result appeared without a finished computation.");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int LEVELS = 64;
    localparam int IDX_W  = $clog2(LEVELS);
    localparam int OUT_W  = ((IDX_W + 2 + 7) / 8) * 8;
    localparam logic [31:0] LVL_MAX = 32'(LEVELS - 1);
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int IDLE_PCT = 26;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic        mode;
        logic [31:0] now;
    } t_ramp_cmd;

    typedef struct {
        logic [IDX_W-1:0] level;
        logic             falling;
        logic             wrapped;
    } t_ramp_level;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [31:0]        i_s_tdata = '0;
    logic               i_s_tuser = 1'b0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_tdata;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [lfrg_pkg::ADDR_W-1:0] paddr = '0;
    logic [lfrg_pkg::APB_W-1:0]  pwdata = '0;
    logic [lfrg_pkg::APB_W-1:0]  prdata;
    logic               pready;

    led_fade_ramp_generator_unit #(.LEVELS(LEVELS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Predictor state and its copy of the configuration.
    logic [lfrg_pkg::PERIOD_W-1:0] period_cfg = lfrg_pkg::PERIOD_RST;
    logic                toggle_cfg = lfrg_pkg::TOGGLE_RST;
    logic [31:0]         ramp_start = '0;
    logic                slope_bit  = lfrg_pkg::SLOPE_RST;

    t_ramp_cmd   pending_cmds[$];
    t_ramp_level level_exp[$];
    t_ramp_cmd   next_cmd;
    t_ramp_level seen_exp;
    int          fail_count = 0;
    logic [31:0] gen_time = '0;
    int unsigned cyc = 0;
    logic        no_idle;

    assign no_idle = (cyc % 16000) >= 12000;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    function automatic logic [31:0] eff_period();
        return (period_cfg == '0) ? 32'd1 :
            {{(32-lfrg_pkg::PERIOD_W){1'b0}}, period_cfg};
    endfunction

    function automatic void ramp_predict(input logic mode, input logic [31:0] now);
        logic [31:0] per;
        logic [31:0] end_t;
        logic [31:0] steps;
        logic [31:0] span;
        logic [31:0] prod;
        logic [31:0] quo;
        t_ramp_level res;
        per = eff_period();
        if (mode == lfrg_pkg::MODE_REALIGN) begin
            ramp_start = now;
            return;
        end
        res.wrapped = 1'b0;
        end_t = ramp_start + per;
        if (now >= end_t) begin
            span = now - ramp_start;
            steps = span / per;
            ramp_start = ramp_start + steps * per;
            if (toggle_cfg) begin
                slope_bit = ~slope_bit;
            end
            res.wrapped = 1'b1;
        end
        span = now - ramp_start;
        prod = LVL_MAX * span;
        quo = prod / per;
        if (quo > LVL_MAX) begin
            quo = LVL_MAX;
        end
        if (slope_bit) begin
            quo = LVL_MAX - quo;
        end
        res.level = quo[IDX_W-1:0];
        res.falling = slope_bit;
        level_exp.push_back(res);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch %s: expected %0d, actual %0d at %0t", what, want, got, $realtime);
        end
    endtask

    // Stream driver: predicts each accepted transaction, then offers the next one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                ramp_predict(i_s_tuser, i_s_tdata);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_cmds.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    next_cmd = pending_cmds.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= next_cmd.now;
                    i_s_tuser <= next_cmd.mode;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (level_exp.size() == 0) begin
                    note_mismatch("unexpected result, tdata", 32'hFFFFFFFF,
                                  {{(32-OUT_W){1'b0}}, o_m_tdata});
                end else begin
                    seen_exp = level_exp.pop_front();
                    if (o_m_tdata[IDX_W-1:0] !== seen_exp.level) begin
                        note_mismatch("level_index", 32'(seen_exp.level),
                                      32'(o_m_tdata[IDX_W-1:0]));
                    end
                    if (o_m_tdata[IDX_W] !== seen_exp.falling) begin
                        note_mismatch("falling", 32'(seen_exp.falling), 32'(o_m_tdata[IDX_W]));
                    end
                    if (o_m_tdata[IDX_W+1] !== seen_exp.wrapped) begin
                        note_mismatch("wrapped", 32'(seen_exp.wrapped),
                                      32'(o_m_tdata[IDX_W+1]));
                    end
                end
            end
            i_m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lfrg_pkg::REG_PERIOD: period_cfg = val[lfrg_pkg::PERIOD_W-1:0];
            lfrg_pkg::REG_TOGGLE: toggle_cfg = val[0];
            default: ;
        endcase
    endtask

    task automatic push_cmd(input logic mode, input logic [31:0] now);
        t_ramp_cmd c;
        c.mode = mode;
        c.now = now;
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || i_s_tvalid || level_exp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random transactions: mostly time moving forward around the period, with realigns,
    // large jumps, samples behind the latest time and starts near the top of the time range.
    task automatic random_phase(input int count);
        logic [31:0] per;
        int unsigned r;
        per = eff_period();
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 10) begin
                if ($urandom_range(2) == 0) begin
                    gen_time = 32'hFFFFFFFF - $urandom_range(0, per);
                end else begin
                    gen_time = gen_time + $urandom_range(0, per);
                end
                push_cmd(lfrg_pkg::MODE_REALIGN, gen_time);
            end else if (r < 60) begin
                gen_time = gen_time + $urandom_range(0, 2 * per);
                push_cmd(lfrg_pkg::MODE_SAMPLE, gen_time);
            end else if (r < 80) begin
                gen_time = gen_time + $urandom_range(0, per / 4);
                push_cmd(lfrg_pkg::MODE_SAMPLE, gen_time);
            end else if (r < 90) begin
                gen_time = $urandom;
                push_cmd(lfrg_pkg::MODE_SAMPLE, gen_time);
            end else begin
                push_cmd(lfrg_pkg::MODE_SAMPLE, gen_time - $urandom_range(0, per));
            end
        end
    endtask

    initial begin
        logic [31:0] per_val;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd0);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd250);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd499);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd500);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd2750);
        push_cmd(lfrg_pkg::MODE_REALIGN, 32'hFFFFFF00);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'hFFFFFF10);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd5);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'hFFFFFFFF);
        push_cmd(lfrg_pkg::MODE_REALIGN, 32'd1000);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd400);
        drain();

        reg_write(lfrg_pkg::REG_PERIOD, 32'hFF000000);
        reg_write(lfrg_pkg::REG_TOGGLE, 32'd0);
        reg_write(lfrg_pkg::REG_SLOPE, 32'd1);
        reg_write(REG_NONE, 32'hFFFFFFFF);
        push_cmd(lfrg_pkg::MODE_REALIGN, 32'd100);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd100);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd101);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd105);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'hFFFFFFFF);
        drain();

        reg_write(lfrg_pkg::REG_PERIOD, 32'h00FFFFFF);
        reg_write(lfrg_pkg::REG_TOGGLE, 32'd1);
        push_cmd(lfrg_pkg::MODE_REALIGN, 32'd0);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd16777214);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd16777215);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'h80000000);
        push_cmd(lfrg_pkg::MODE_SAMPLE, 32'd0);
        drain();

        gen_time = '0;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: per_val = 32'd1;
                1: per_val = 32'h00FFFFFF;
                2: per_val = 32'd500;
                default: begin
                    case ($urandom_range(3))
                        0: per_val = $urandom_range(1, 8);
                        1: per_val = $urandom_range(9, 1000);
                        2: per_val = $urandom_range(1001, 32'h00FFFFFF);
                        default: per_val = 32'd0;
                    endcase
                end
            endcase
            reg_write(lfrg_pkg::REG_PERIOD, per_val);
            reg_write(lfrg_pkg::REG_TOGGLE, $urandom_range(1));
            reg_write(lfrg_pkg::REG_SLOPE, $urandom_range(1));
            random_phase(125);
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
